### rtl/core/lpws_pkg.sv
// Package for the LED pulse-width serializer.
// Holds the item, result and configuration types plus register codes.
// No dependencies.
`timescale 1ns / 1ps

package lpws_pkg;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_LOW   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LATCH_LOW = 3'd4;
    localparam int unsigned CFG_DATA_W = 16;

    // Reset values of the timing registers
    localparam logic [7:0]  RST_ZERO_HIGH = 8'd28;
    localparam logic [7:0]  RST_ZERO_LOW  = 8'd64;
    localparam logic [7:0]  RST_ONE_HIGH  = 8'd56;
    localparam logic [7:0]  RST_ONE_LOW   = 8'd48;
    localparam logic [15:0] RST_LATCH_LOW = 16'd4400;

    // Bits per colour byte
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    // Input kind carried on tuser
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    // Line phase, one-hot
    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_HIGH  = 4'b0010,
        PH_LOW   = 4'b0100,
        PH_LATCH = 4'b1000
    } phase_t;

    // Classified input item
    typedef struct packed {
        logic       is_load;
        logic [7:0] data_byte;
        logic       end_of_frame;
    } item_t;

    // Result, line_level in the lowest bit
    typedef struct packed {
        logic busy_res;
        logic frame_done;
        logic byte_done;
        logic accepted;
        logic line_level;
    } result_t;

    // Timing configuration
    typedef struct packed {
        logic [7:0]  zero_high_ticks;
        logic [7:0]  zero_low_ticks;
        logic [7:0]  one_high_ticks;
        logic [7:0]  one_low_ticks;
        logic [15:0] latch_low_ticks;
    } cfg_t;

endpackage

### rtl/core/lpws_front.sv
// Front stage of the LED pulse-width serializer: accepts input transactions
// and classifies them into items for the queue. Depends on lpws_pkg.
`timescale 1ns / 1ps

module lpws_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [7:0]     s_tdata,   // [7:0] data_byte
    input  logic           s_tlast,
    input  logic [0:0]     s_tuser,   // [0] op
    output logic           item_valid,
    input  logic           item_ready,
    output lpws_pkg::item_t item
);

    logic            valid_reg, valid_next;
    lpws_pkg::item_t item_reg, item_next;

    // Take a new transaction whenever the slot is empty or draining
    assign s_tready = !valid_reg || item_ready;

    // Classify: ticks carry no byte and no frame mark
    always_comb begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (s_tready) begin
            valid_next = s_tvalid;
            item_next.is_load      = (s_tuser[0] == lpws_pkg::OP_LOAD);
            item_next.data_byte    = (s_tuser[0] == lpws_pkg::OP_LOAD) ? s_tdata : 8'd0;
            item_next.end_of_frame = (s_tuser[0] == lpws_pkg::OP_LOAD) && s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        item_reg <= item_next;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

### rtl/core/lpws_queue.sv
// Short item queue between the front and back of the serializer.
// Depends on lpws_pkg.
`timescale 1ns / 1ps

module lpws_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push_valid,
    output logic            push_ready,
    input  lpws_pkg::item_t push_item,
    output logic            pop_valid,
    input  logic            pop_ready,
    output lpws_pkg::item_t pop_item
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    lpws_pkg::item_t  entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Advance pointers with wrap and track fill level
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed items
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### rtl/core/lpws_back.sv
// Back end of the serializer: runs the pulse timing state machine on each
// queued item and holds the result register. Depends on lpws_pkg.
`timescale 1ns / 1ps

module lpws_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  lpws_pkg::cfg_t    cfg,
    input  logic              item_valid,
    output logic              item_ready,
    input  lpws_pkg::item_t   item,
    output logic              res_valid,
    input  logic              res_ready,
    output lpws_pkg::result_t res
);

    lpws_pkg::phase_t  phase_reg, phase_next;
    logic [7:0]        shifter_reg, shifter_next;
    logic [3:0]        bits_left_reg, bits_left_next;
    logic [15:0]       tick_count_reg, tick_count_next;
    logic              frame_ending_reg, frame_ending_next;
    logic              out_valid_reg, out_valid_next;
    lpws_pkg::result_t out_reg, out_next;

    logic       one_bit;
    logic [7:0] high_dur, low_dur;
    logic [15:0] tick_inc;
    logic       step;

    // Pop an item whenever the result slot is free or being taken
    assign step       = item_valid && (!out_valid_reg || res_ready);
    assign item_ready = !out_valid_reg || res_ready;

    assign one_bit  = shifter_reg[7];
    assign high_dur = one_bit ? cfg.one_high_ticks : cfg.zero_high_ticks;
    assign low_dur  = one_bit ? cfg.one_low_ticks  : cfg.zero_low_ticks;
    assign tick_inc = tick_count_reg + 16'd1;

    // Next line state and result for the item at the queue head
    always_comb begin
        phase_next        = phase_reg;
        shifter_next      = shifter_reg;
        bits_left_next    = bits_left_reg;
        tick_count_next   = tick_count_reg;
        frame_ending_next = frame_ending_reg;
        out_next          = out_reg;
        out_valid_next    = out_valid_reg;
        if (res_ready) begin
            out_valid_next = 1'b0;
        end
        if (step) begin
            out_next       = '0;
            out_valid_next = 1'b1;
            if (item.is_load) begin
                if (phase_reg == lpws_pkg::PH_IDLE) begin
                    shifter_next      = item.data_byte;
                    bits_left_next    = lpws_pkg::BITS_PER_BYTE;
                    frame_ending_next = item.end_of_frame;
                    phase_next        = lpws_pkg::PH_HIGH;
                    tick_count_next   = '0;
                    out_next.accepted = 1'b1;
                end
            end else begin
                unique case (phase_reg)
                    lpws_pkg::PH_HIGH: begin
                        tick_count_next = tick_inc;
                        if (tick_inc >= {8'd0, high_dur}) begin
                            phase_next      = lpws_pkg::PH_LOW;
                            tick_count_next = '0;
                        end
                    end
                    lpws_pkg::PH_LOW: begin
                        tick_count_next = tick_inc;
                        if (tick_inc >= {8'd0, low_dur}) begin
                            shifter_next    = {shifter_reg[6:0], 1'b0};
                            tick_count_next = '0;
                            if (bits_left_reg != 4'd0) begin
                                bits_left_next = bits_left_reg - 4'd1;
                            end
                            if (bits_left_reg <= 4'd1) begin
                                out_next.byte_done = 1'b1;
                                phase_next = frame_ending_reg ? lpws_pkg::PH_LATCH
                                                              : lpws_pkg::PH_IDLE;
                                frame_ending_next = 1'b0;
                            end else begin
                                phase_next = lpws_pkg::PH_HIGH;
                            end
                        end
                    end
                    lpws_pkg::PH_LATCH: begin
                        tick_count_next = tick_inc;
                        if (tick_inc >= cfg.latch_low_ticks) begin
                            out_next.frame_done = 1'b1;
                            phase_next          = lpws_pkg::PH_IDLE;
                            tick_count_next     = '0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            out_next.line_level = (phase_next == lpws_pkg::PH_HIGH);
            out_next.busy_res   = (phase_next != lpws_pkg::PH_IDLE);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= lpws_pkg::PH_IDLE;
            shifter_reg      <= '0;
            bits_left_reg    <= '0;
            tick_count_reg   <= '0;
            frame_ending_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else begin
            phase_reg        <= phase_next;
            shifter_reg      <= shifter_next;
            bits_left_reg    <= bits_left_next;
            tick_count_reg   <= tick_count_next;
            frame_ending_reg <= frame_ending_next;
            out_valid_reg    <= out_valid_next;
        end
        out_reg <= out_next;
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    // A taken load always starts a high pulse
    a_load_starts_high: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.accepted) |-> (out_reg.line_level && out_reg.busy_res))
        else $error("accepted load did not start a high pulse");

    // Frame completion leaves the line idle
    a_frame_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.frame_done) |-> !out_reg.busy_res)
        else $error("frame_done while still busy");

    // Byte completion never coincides with a high level
    a_byte_done_low: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.byte_done) |-> !out_reg.line_level)
        else $error("byte_done with line high");

    // Bit counter stays within one byte
    a_bits_range: assert property (@(posedge aclk) disable iff (!aresetn)
        bits_left_reg <= lpws_pkg::BITS_PER_BYTE)
        else $error("bit counter out of range");

    // Bit pulses never count past an 8-bit duration
    a_pulse_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == lpws_pkg::PH_HIGH || phase_reg == lpws_pkg::PH_LOW)
            |-> (tick_count_reg[15:8] == 8'd0))
        else $error("pulse tick count exceeds 8 bits");

endmodule

### rtl/core/led_pulse_width_serializer_top.sv
// LED pulse-width serializer, top level: ports, timing registers and the
// front / queue / back chain. Depends on lpws_pkg, lpws_front, lpws_queue, lpws_back.
`timescale 1ns / 1ps

// Drives one addressable-LED data line. Each input transaction is either a
// tick of time (tuser 0) or a byte load (tuser 1, byte on tdata, tlast marks
// the last byte of a frame), and each gives exactly one result transaction
// with line_level, accepted, byte_done, frame_done and busy_res. Bytes go out
// MSB first, each bit a high pulse then a low pulse whose lengths in ticks
// come from the timing registers; after a frame's last byte the line stays
// low for latch_low_ticks. A load while busy is refused (accepted 0). The
// block takes one transaction per clock cycle while the result stream is not
// held back; each result passes through the front register, the item queue and
// the result register, and the pulse state machine in the back end updates
// once per item. Timing registers reset to 28/64/56/48/4400 and are written
// on the cfg channel, which is always ready; write them only while idle.

module led_pulse_width_serializer_top #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] data_byte
    input  logic                              s_tlast,   // end_of_frame
    input  logic [0:0]                        s_tuser,   // [0] op
    // Result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [0] line_level, [1] accepted, [2] byte_done, [3] frame_done,
    // [4] busy_res, [7:5] zero
    output logic [7:0]                        m_tdata,
    // Configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lpws_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lpws_pkg::CFG_DATA_W-1:0]   cfg_data
);

    lpws_pkg::cfg_t    cfg_reg, cfg_next;
    lpws_pkg::item_t   front_item, queue_item;
    lpws_pkg::result_t result;
    logic              front_valid, front_ready;
    logic              queue_valid, queue_ready;

    assign cfg_ready = 1'b1;

    // Decode configuration writes
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                lpws_pkg::CFG_ZERO_HIGH: cfg_next.zero_high_ticks = cfg_data[7:0];
                lpws_pkg::CFG_ZERO_LOW:  cfg_next.zero_low_ticks  = cfg_data[7:0];
                lpws_pkg::CFG_ONE_HIGH:  cfg_next.one_high_ticks  = cfg_data[7:0];
                lpws_pkg::CFG_ONE_LOW:   cfg_next.one_low_ticks   = cfg_data[7:0];
                lpws_pkg::CFG_LATCH_LOW: cfg_next.latch_low_ticks = cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.zero_high_ticks <= lpws_pkg::RST_ZERO_HIGH;
            cfg_reg.zero_low_ticks  <= lpws_pkg::RST_ZERO_LOW;
            cfg_reg.one_high_ticks  <= lpws_pkg::RST_ONE_HIGH;
            cfg_reg.one_low_ticks   <= lpws_pkg::RST_ONE_LOW;
            cfg_reg.latch_low_ticks <= lpws_pkg::RST_LATCH_LOW;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    lpws_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .s_tuser    (s_tuser),
        .item_valid (front_valid),
        .item_ready (front_ready),
        .item       (front_item)
    );

    lpws_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_item  (front_item),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_item   (queue_item)
    );

    lpws_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .item_valid (queue_valid),
        .item_ready (queue_ready),
        .item       (queue_item),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res        (result)
    );

    assign m_tdata = {3'b000, result};

endmodule

### tb/tb_led_pulse_width_serializer_top.sv
// Testbench for led_pulse_width_serializer_top: drives tick and byte-load
// transactions, predicts line level and status flags, and checks every result.
// Depends on lpws_pkg and the serializer RTL.
`timescale 1ns / 1ps

module tb_led_pulse_width_serializer_top;

    localparam int unsigned CYCLE_LIMIT  = 100_000;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          HOLD_CYCLES  = 300;

    // One pending input transaction; after_drain holds it until all results are in
    typedef struct {
        logic       op;
        logic [7:0] data;
        logic       eof;
        bit         after_drain;
    } line_item_t;

    logic                                aclk = 1'b0;
    logic                                aresetn = 1'b0;
    logic                                s_tvalid = 1'b0;
    logic                                s_tready;
    logic [7:0]                          s_tdata = '0;
    logic                                s_tlast = 1'b0;
    logic [0:0]                          s_tuser = '0;
    logic                                m_tvalid;
    logic                                m_tready = 1'b0;
    logic [7:0]                          m_tdata;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [lpws_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
    logic [lpws_pkg::CFG_DATA_W-1:0]     cfg_data = '0;

    // Stimulus and scoreboard
    line_item_t          items_todo[$];
    lpws_pkg::result_t   line_results_due[$];
    int unsigned  n_queued = 0;
    int unsigned  n_accepted = 0;
    int unsigned  n_results = 0;
    int unsigned  n_errors = 0;
    int unsigned  cycle_count = 0;
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    int           hold_left = 0;
    bit           hold_armed = 1'b0;

    // Predictor state and shadow of the timing registers
    lpws_pkg::cfg_t    cfg_shadow;
    lpws_pkg::phase_t  line_phase;
    logic [7:0]   shift_bits;
    logic [3:0]   bits_left;
    logic [15:0]  tick_cnt;
    logic         frame_pending;
    int unsigned  n_loads_taken = 0;
    int unsigned  n_bytes_done = 0;
    int unsigned  n_frames_done = 0;

    led_pulse_width_serializer_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Advance the line state by one transaction and return the result it gives
    function automatic lpws_pkg::result_t predict_line_item(input logic is_load,
                                                            input logic [7:0] byte_in,
                                                            input logic eof);
        lpws_pkg::result_t res;
        logic        one_bit;
        logic [15:0] pulse_len;
        res = '0;
        one_bit = shift_bits[7];
        if (is_load) begin
            if (line_phase == lpws_pkg::PH_IDLE) begin
                shift_bits = byte_in;
                bits_left = lpws_pkg::BITS_PER_BYTE;
                frame_pending = eof;
                line_phase = lpws_pkg::PH_HIGH;
                tick_cnt = '0;
                res.accepted = 1'b1;
                n_loads_taken++;
            end
        end else if (line_phase != lpws_pkg::PH_IDLE) begin
            tick_cnt = tick_cnt + 16'd1;
            case (line_phase)
                lpws_pkg::PH_HIGH: pulse_len = {8'd0, one_bit ? cfg_shadow.one_high_ticks
                                                              : cfg_shadow.zero_high_ticks};
                lpws_pkg::PH_LOW:  pulse_len = {8'd0, one_bit ? cfg_shadow.one_low_ticks
                                                              : cfg_shadow.zero_low_ticks};
                default:           pulse_len = cfg_shadow.latch_low_ticks;
            endcase
            // End the pulse on its last tick
            if (tick_cnt >= pulse_len) begin
                tick_cnt = '0;
                case (line_phase)
                    lpws_pkg::PH_HIGH: line_phase = lpws_pkg::PH_LOW;
                    lpws_pkg::PH_LOW: begin
                        shift_bits = shift_bits << 1;
                        if (bits_left != 0) bits_left--;
                        if (bits_left == 0) begin
                            res.byte_done = 1'b1;
                            n_bytes_done++;
                            line_phase = frame_pending ? lpws_pkg::PH_LATCH
                                                       : lpws_pkg::PH_IDLE;
                            frame_pending = 1'b0;
                        end else begin
                            line_phase = lpws_pkg::PH_HIGH;
                        end
                    end
                    default: begin
                        res.frame_done = 1'b1;
                        n_frames_done++;
                        line_phase = lpws_pkg::PH_IDLE;
                    end
                endcase
            end
        end
        res.line_level = (line_phase == lpws_pkg::PH_HIGH);
        res.busy_res = (line_phase != lpws_pkg::PH_IDLE);
        return res;
    endfunction

    function automatic void check_flag(input string name, input logic want, input logic got);
        if (got !== want) begin
            $error("%s: expected %0b, actual %0b", name, want, got);
            n_errors++;
        end
    endfunction

    // Ticks needed to send one byte and, if marked, its latch time
    function automatic int byte_ticks(input logic [7:0] b, input logic eof);
        int n;
        n = 0;
        for (int i = 7; i >= 0; i--) begin
            n += b[i] ? int'(cfg_shadow.one_high_ticks) + int'(cfg_shadow.one_low_ticks)
                      : int'(cfg_shadow.zero_high_ticks) + int'(cfg_shadow.zero_low_ticks);
        end
        if (eof) n += int'(cfg_shadow.latch_low_ticks);
        return n;
    endfunction

    function automatic void queue_item(input logic op, input logic [7:0] data, input logic eof,
                                       input bit after_drain);
        line_item_t it;
        it.op = op;
        it.data = data;
        it.eof = eof;
        it.after_drain = after_drain;
        items_todo.push_back(it);
        n_queued++;
    endfunction

    // Queue a load and the ticks that send it; noisy adds refused loads,
    // early cuts, spare ticks and the odd pause for a full drain
    task automatic queue_byte(input logic [7:0] b, input logic eof, input bit noisy);
        int ticks;
        int cut;
        ticks = byte_ticks(b, eof);
        cut = (noisy && $urandom_range(19) == 0) ? $urandom_range(ticks - 1) : ticks;
        queue_item(lpws_pkg::OP_LOAD, b, eof, noisy && $urandom_range(29) == 0);
        for (int i = 0; i < cut; i++) begin
            if (noisy && $urandom_range(15) == 0)
                queue_item(lpws_pkg::OP_LOAD, 8'($urandom_range(255)),
                           1'($urandom_range(1)), 1'b0);
            queue_item(lpws_pkg::OP_TICK, 8'($urandom_range(255)),
                       1'($urandom_range(1)), 1'b0);
        end
        if (noisy) begin
            repeat ($urandom_range(2))
                queue_item(lpws_pkg::OP_TICK, 8'($urandom_range(255)),
                           1'($urandom_range(1)), 1'b0);
        end
    endtask

    // Hold until every transaction is taken and every result is back
    task automatic wait_drained();
        while (n_accepted != n_queued || line_results_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [lpws_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            lpws_pkg::CFG_ZERO_HIGH: cfg_shadow.zero_high_ticks = val[7:0];
            lpws_pkg::CFG_ZERO_LOW:  cfg_shadow.zero_low_ticks = val[7:0];
            lpws_pkg::CFG_ONE_HIGH:  cfg_shadow.one_high_ticks = val[7:0];
            lpws_pkg::CFG_ONE_LOW:   cfg_shadow.one_low_ticks = val[7:0];
            lpws_pkg::CFG_LATCH_LOW: cfg_shadow.latch_low_ticks = val;
            default: ;
        endcase
    endtask

    task automatic load_timing(input logic [7:0] zh, input logic [7:0] zl, input logic [7:0] oh,
                               input logic [7:0] ol, input logic [15:0] latch);
        write_reg(lpws_pkg::CFG_ZERO_HIGH, {8'd0, zh});
        write_reg(lpws_pkg::CFG_ZERO_LOW, {8'd0, zl});
        write_reg(lpws_pkg::CFG_ONE_HIGH, {8'd0, oh});
        write_reg(lpws_pkg::CFG_ONE_LOW, {8'd0, ol});
        write_reg(lpws_pkg::CFG_LATCH_LOW, latch);
    endtask

    // Driver: predict on each accepted transaction, then offer the next one
    always @(posedge aclk) begin
        line_item_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                line_results_due.push_back(
                    predict_line_item(s_tuser[0] == lpws_pkg::OP_LOAD, s_tdata, s_tlast));
                n_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (items_todo.size() > 0
                    && !(items_todo[0].after_drain && line_results_due.size() > 0)
                    && $urandom_range(99) >= send_idle_pct) begin
                    nxt = items_todo.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= nxt.data;
                    s_tlast <= nxt.eof;
                    s_tuser <= nxt.op;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result with the oldest prediction, stall at random
    always @(posedge aclk) begin
        lpws_pkg::result_t got;
        lpws_pkg::result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = lpws_pkg::result_t'(m_tdata[4:0]);
                if (line_results_due.size() == 0) begin
                    $error("result with nothing expected: m_tdata %02h", m_tdata);
                    n_errors++;
                end else begin
                    want = line_results_due.pop_front();
                    check_flag("line_level", want.line_level, got.line_level);
                    check_flag("accepted", want.accepted, got.accepted);
                    check_flag("byte_done", want.byte_done, got.byte_done);
                    check_flag("frame_done", want.frame_done, got.frame_done);
                    check_flag("busy_res", want.busy_res, got.busy_res);
                end
                n_results++;
                // Hold off long enough to back the block up to its input
                if (hold_armed && items_todo.size() > 100) begin
                    hold_left = HOLD_CYCLES;
                    hold_armed = 1'b0;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Stop a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_led_pulse_width_serializer_top failed");
            $finish;
        end
    end

    initial begin
        cfg_shadow.zero_high_ticks = lpws_pkg::RST_ZERO_HIGH;
        cfg_shadow.zero_low_ticks = lpws_pkg::RST_ZERO_LOW;
        cfg_shadow.one_high_ticks = lpws_pkg::RST_ONE_HIGH;
        cfg_shadow.one_low_ticks = lpws_pkg::RST_ONE_LOW;
        cfg_shadow.latch_low_ticks = lpws_pkg::RST_LATCH_LOW;
        line_phase = lpws_pkg::PH_IDLE;
        shift_bits = '0;
        bits_left = '0;
        tick_cnt = '0;
        frame_pending = 1'b0;
        send_idle_pct = 29;
        recv_idle_pct = 75;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset timing: idle tick, a zero bit at its reset lengths, a refused load
        queue_item(lpws_pkg::OP_TICK, 8'hFF, 1'b1, 1'b0);
        queue_item(lpws_pkg::OP_LOAD, 8'h00, 1'b1, 1'b0);
        queue_item(lpws_pkg::OP_LOAD, 8'h3C, 1'b0, 1'b0);
        repeat (94) queue_item(lpws_pkg::OP_TICK, 8'h00, 1'b0, 1'b0);
        wait_drained();

        // Shortest pulses; first finish the byte left running under the new timing
        load_timing(8'd1, 8'd1, 8'd1, 8'd1, 16'd1);
        repeat (18) queue_item(lpws_pkg::OP_TICK, 8'h00, 1'b0, 1'b0);
        queue_byte(8'hFF, 1'b0, 1'b0);
        queue_item(lpws_pkg::OP_TICK, 8'h5A, 1'b0, 1'b0);
        queue_byte(8'h00, 1'b1, 1'b0);
        queue_item(lpws_pkg::OP_TICK, 8'h00, 1'b1, 1'b1);
        queue_byte(8'hA5, 1'b0, 1'b1);
        wait_drained();

        // Random frames over three idling profiles
        for (int p = 0; p < 5; p++) begin
            int top;
            top = (p % 2 == 1) ? 3 : 2;
            if (p == 2) begin
                send_idle_pct = 75;
                recv_idle_pct = 29;
            end else if (p == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            load_timing(8'($urandom_range(top, 1)), 8'($urandom_range(top, 1)),
                        8'($urandom_range(top, 1)), 8'($urandom_range(top, 1)),
                        16'($urandom_range(8, 1)));
            repeat (2) queue_byte(8'($urandom_range(255)), $urandom_range(3) == 0, 1'b1);
            wait_drained();
        end

        // Longest high pulse, with the output held off while the input keeps coming
        load_timing(8'd255, 8'd1, 8'd1, 8'd1, 16'd1);
        hold_armed = 1'b1;
        queue_item(lpws_pkg::OP_LOAD, 8'h00, 1'b0, 1'b0);
        repeat (258) queue_item(lpws_pkg::OP_TICK, 8'h00, 1'b0, 1'b0);
        wait_drained();

        $display("%0d transactions checked: %0d bytes loaded, %0d sent, %0d frames latched",
                 n_results, n_loads_taken, n_bytes_done, n_frames_done);
        $display("covered reset pulse lengths, 1 to 255 tick pulses, refused loads, %s",
                 "timing changes mid-byte and a long output stall");
        if (n_errors == 0) begin
            $display("tb_led_pulse_width_serializer_top passed");
        end else begin
            $display("tb_led_pulse_width_serializer_top failed");
        end
        $finish;
    end

endmodule
